### hw/rtl/brrd_pkg.sv
// ----------------------------------------------------------------------------
// brrd_pkg
// Shared types and constants of the bitmap run-length row decoder.
// ----------------------------------------------------------------------------
package brrd_pkg;

  // up to two decoded bytes travel in each result
  localparam int unsigned BytesPerResult = 2;
  localparam int unsigned QueueDepth     = 4;

  localparam int unsigned RegIdxW = 2;
  localparam int unsigned RegDataW = 16;

  // configuration register indexes
  localparam logic [RegIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [RegIdxW-1:0] RegImageHeight = 2'd1;
  localparam logic [RegIdxW-1:0] RegPixelDepth  = 2'd2;
  localparam logic [RegIdxW-1:0] RegRunCoded    = 2'd3;

  localparam logic [4:0] DepthReset = 5'd8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte_a;
    logic [7:0] out_byte_b;
    logic [1:0] byte_count;
    logic       row_end;
    logic       image_done;
    logic       last_of_item;
  } out_item_t;

  typedef struct packed {
    logic [RegIdxW-1:0]  reg_index;
    logic [RegDataW-1:0] reg_data;
  } cfg_write_t;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [4:0]  pixel_depth;
    logic        run_coded;
  } cfg_t;

  // one decoded packet piece handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] n_bytes;
    logic       row_end;
    logic       image_done;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic empty;
  } queue_ctl_t;

endpackage

### hw/rtl/brrd_intf.sv
// ----------------------------------------------------------------------------
// brrd interfaces
// Valid/ready channels for input bytes, results and register writes.
// ----------------------------------------------------------------------------
interface brrd_in_if;
  logic                valid;
  logic                ready;
  brrd_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface brrd_out_if;
  logic                valid;
  logic                ready;
  brrd_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface brrd_cfg_if;
  logic                 valid;
  logic                 ready;
  brrd_pkg::cfg_write_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/bitmap_rle_row_decoder.sv
// ----------------------------------------------------------------------------
// bitmap_rle_row_decoder
// Row decoder for raw or run-length coded bitmap pixel data.
// ----------------------------------------------------------------------------
// The front takes one coded byte per cycle while the command queue has room
// and turns it into a command; the back sends one result per cycle while
// the output is taken, from a registered output stage. A literal, raw or
// control byte gives one result, a repeat byte of a run of n bytes gives
// ceil(n/2) results, so a run of 128 gives 64 results. Input is refused
// only while the QueueDepth-entry command queue between the two is full, so
// several short items can pass during a run. Registers may be written at
// any time the block is idle; writes are always taken.
module bitmap_rle_row_decoder #(
  parameter int unsigned QueueDepth = brrd_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  brrd_in_if.sink      in_i,
  brrd_out_if.source   out_o,
  brrd_cfg_if.sink     cfg_i
);

  brrd_pkg::cfg_t       cfg_q;
  brrd_pkg::cmd_t       push_cmd, head_cmd;
  brrd_pkg::queue_ctl_t q_stat;
  logic                 push, pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 16'd0;
      cfg_q.image_height <= 16'd0;
      cfg_q.pixel_depth  <= brrd_pkg::DepthReset;
      cfg_q.run_coded    <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.reg_index)
        brrd_pkg::RegImageWidth:  cfg_q.image_width  <= cfg_i.payload.reg_data;
        brrd_pkg::RegImageHeight: cfg_q.image_height <= cfg_i.payload.reg_data;
        brrd_pkg::RegPixelDepth:  cfg_q.pixel_depth  <= cfg_i.payload.reg_data[4:0];
        brrd_pkg::RegRunCoded:    cfg_q.run_coded    <= cfg_i.payload.reg_data[0];
        default:                  cfg_q <= cfg_q;
      endcase
    end
  end

  brrd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_i.valid),
    .in_item_i  (in_i.payload),
    .in_ready_o (in_i.ready),
    .q_full_i   (q_stat.full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  brrd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cmd_i (push_cmd),
    .head_cmd_o (head_cmd),
    .status_o   (q_stat),
    .push_i     (push),
    .pop_i      (pop)
  );

  brrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_cmd_i  (head_cmd),
    .q_empty_i   (q_stat.empty),
    .q_pop_o     (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.payload)
  );

endmodule

### hw/rtl/brrd_front.sv
// ----------------------------------------------------------------------------
// brrd_front
// Accepts coded bytes, tracks packet phase, columns and rows, and issues
// one command per byte.
// ----------------------------------------------------------------------------
module brrd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brrd_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  input  brrd_pkg::in_item_t  in_item_i,
  output logic                in_ready_o,
  input  logic                q_full_i,
  output logic                q_push_o,
  output brrd_pkg::cmd_t      q_cmd_o
);

  localparam logic [1:0] PhControl = 2'd0;
  localparam logic [1:0] PhRepeat  = 2'd1;
  localparam logic [1:0] PhLiteral = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  lit_q, lit_d;
  logic [7:0]  rep_q, rep_d;
  logic [17:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic        fin_q, fin_d;

  logic [1:0]  phase_e;
  logic [7:0]  lit_e, rep_e, lit_dec, add, v;
  logic [17:0] col_e, col_sum, row_bytes, w18;
  logic [15:0] row_e, row_inc;
  logic        fin_e, pkt_end, row_done, accept;

  assign accept     = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;
  assign q_push_o   = accept;
  assign v          = in_item_i.in_byte;
  assign w18        = {2'b00, cfg_i.image_width};

  always_comb begin
    case (cfg_i.pixel_depth)
      5'd1:    row_bytes = (w18 + 18'd7) >> 3;
      5'd24:   row_bytes = {1'b0, cfg_i.image_width, 1'b0} + w18;
      default: row_bytes = w18;
    endcase
  end

  always_comb begin
    // frame start restarts everything before the byte is decoded
    phase_e = in_item_i.frame_start ? PhControl : phase_q;
    lit_e   = in_item_i.frame_start ? 8'd0 : lit_q;
    rep_e   = in_item_i.frame_start ? 8'd0 : rep_q;
    col_e   = in_item_i.frame_start ? 18'd0 : col_q;
    row_e   = in_item_i.frame_start ? 16'd0 : row_q;
    fin_e   = in_item_i.frame_start ? 1'b0 : fin_q;

    phase_d = phase_e;
    lit_d   = lit_e;
    rep_d   = rep_e;
    add     = 8'd0;
    pkt_end = 1'b0;
    lit_dec = lit_e - 8'd1;
    q_cmd_o.data_byte = v;
    q_cmd_o.n_bytes   = 8'd0;

    if (fin_e) begin
      q_cmd_o.n_bytes = 8'd0;
    end else if (!cfg_i.run_coded) begin
      q_cmd_o.n_bytes = 8'd1;
      add     = 8'd1;
      pkt_end = 1'b1;
    end else begin
      case (phase_e)
        PhRepeat: begin
          q_cmd_o.n_bytes = rep_e;
          add     = rep_e;
          phase_d = PhControl;
          pkt_end = 1'b1;
        end
        PhLiteral: begin
          q_cmd_o.n_bytes = 8'd1;
          add   = 8'd1;
          lit_d = lit_dec;
          if (lit_dec == 8'd0) begin
            phase_d = PhControl;
            pkt_end = 1'b1;
          end
        end
        default: begin
          if (v > 8'h80) begin
            // 0x101 - v, kept to eight bits
            rep_d   = 8'd1 - v;
            phase_d = PhRepeat;
          end else if (v == 8'd0) begin
            phase_d = PhControl;
            pkt_end = 1'b1;
          end else begin
            lit_d   = v;
            phase_d = PhLiteral;
          end
        end
      endcase
    end

    col_sum  = col_e + {10'd0, add};
    row_inc  = row_e + 16'd1;
    row_done = pkt_end && (col_sum >= row_bytes);
    col_d    = row_done ? 18'd0 : col_sum;
    row_d    = row_done ? row_inc : row_e;
    fin_d    = fin_e || (row_done && (row_inc >= cfg_i.image_height));

    q_cmd_o.row_end    = row_done;
    q_cmd_o.image_done = fin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhControl;
      lit_q   <= 8'd0;
      rep_q   <= 8'd0;
      col_q   <= 18'd0;
      row_q   <= 16'd0;
      fin_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      rep_q   <= rep_d;
      col_q   <= col_d;
      row_q   <= row_d;
      fin_q   <= fin_d;
    end
  end

endmodule

### hw/rtl/brrd_queue.sv
// ----------------------------------------------------------------------------
// brrd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module brrd_queue #(
  parameter int unsigned Depth = brrd_pkg::QueueDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  brrd_pkg::cmd_t         push_cmd_i,
  output brrd_pkg::cmd_t         head_cmd_o,
  output brrd_pkg::queue_ctl_t   status_o,
  input  logic                   push_i,
  input  logic                   pop_i
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [AddrW:0]   DepthCnt = (AddrW + 1)'(Depth);

  brrd_pkg::cmd_t     mem_q [Depth];
  logic [AddrW-1:0]   wr_q, rd_q;
  logic [AddrW:0]     cnt_q;
  logic               full, empty, do_push, do_pop;

  assign full    = (cnt_q == DepthCnt);
  assign empty   = (cnt_q == '0);
  assign do_push = push_i && !full;
  assign do_pop  = pop_i && !empty;

  assign head_cmd_o      = mem_q[rd_q];
  assign status_o.push   = do_push;
  assign status_o.full   = full;
  assign status_o.pop    = do_pop;
  assign status_o.empty  = empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastAddr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastAddr) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### hw/rtl/brrd_back.sv
// ----------------------------------------------------------------------------
// brrd_back
// Expands each command into results of up to two bytes, one per cycle while
// the output is taken, through a registered output stage.
// ----------------------------------------------------------------------------
module brrd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brrd_pkg::cmd_t      head_cmd_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output brrd_pkg::out_item_t out_item_o
);

  localparam logic [7:0] Bpr = 8'(brrd_pkg::BytesPerResult);

  brrd_pkg::cmd_t      cur_q;
  logic [7:0]          rem_q;
  logic                busy_q;
  logic                out_valid_q;
  brrd_pkg::out_item_t out_q;

  brrd_pkg::cmd_t      src;
  logic [7:0]          src_rem;
  logic [1:0]          cnt;
  logic                have, slot_free, emit, last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign src       = busy_q ? cur_q : head_cmd_i;
  assign src_rem   = busy_q ? rem_q : head_cmd_i.n_bytes;
  assign have      = busy_q || !q_empty_i;
  assign emit      = have && slot_free;
  assign last      = (src_rem <= Bpr);
  assign cnt       = last ? src_rem[1:0] : 2'd2;
  // a command leaves the queue as soon as its first result goes out
  assign q_pop_o   = emit && !busy_q;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cur_q                <= src;
      rem_q                <= src_rem - Bpr;
      out_q.out_byte_a     <= (cnt != 2'd0) ? src.data_byte : 8'd0;
      out_q.out_byte_b     <= (cnt == 2'd2) ? src.data_byte : 8'd0;
      out_q.byte_count     <= cnt;
      out_q.row_end        <= last && src.row_end;
      out_q.image_done     <= last && src.image_done;
      out_q.last_of_item   <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        busy_q      <= !last;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### tb/sv/bitmap_rle_row_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_rle_row_decoder_tb
// Drives raw and run-length coded pixel bytes through the row decoder, with
// random idling on both channels. Each accepted byte is run through a
// scoreboard that tracks the decode state and queues the results it implies;
// every result taken from the block is checked against the oldest one.
// ----------------------------------------------------------------------------
package brrd_tb_pkg;
  import brrd_pkg::*;

  typedef enum logic [1:0] {
    PhControl,
    PhRepeat,
    PhLiteral
  } decode_phase_e;

  // control bytes above this start a run, from one up to it a literal packet
  localparam logic [7:0] LiteralMax = 8'h80;
  localparam logic [8:0] RunBase    = 9'h101;
  localparam logic [4:0] DepthMono  = 5'd1;
  localparam logic [4:0] DepthTrue  = 5'd24;

  class rle_row_scoreboard;
    out_item_t     pending_q[$];
    out_item_t     byte_res[$];
    logic [15:0]   img_width;
    logic [15:0]   img_height;
    logic [4:0]    depth;
    logic          run_mode;
    decode_phase_e phase;
    logic [7:0]    literal_left;
    logic [7:0]    repeat_len;
    logic [17:0]   column;
    logic [15:0]   row;
    logic          done;
    int            errors;

    function new();
      img_width  = '0;
      img_height = '0;
      depth      = DepthReset;
      run_mode   = 1'b0;
      errors     = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      column       = '0;
      row          = '0;
      done         = 1'b0;
      phase        = PhControl;
      literal_left = '0;
      repeat_len   = '0;
    endfunction

    function void write_reg(logic [RegIdxW-1:0] idx, logic [RegDataW-1:0] data);
      case (idx)
        RegImageWidth:  img_width = data;
        RegImageHeight: img_height = data;
        RegPixelDepth:  depth = data[4:0];
        RegRunCoded:    run_mode = data[0];
        default: ;
      endcase
    endfunction

    function logic [17:0] row_width();
      if (depth == DepthMono) return ({2'b00, img_width} + 18'd7) >> 3;
      if (depth == DepthTrue) return {2'b00, img_width} * 18'd3;
      return {2'b00, img_width};
    endfunction

    function void put(logic [7:0] a, logic [7:0] b, logic [1:0] n);
      out_item_t r;
      r.out_byte_a   = a;
      r.out_byte_b   = b;
      r.byte_count   = n;
      r.row_end      = 1'b0;
      r.image_done   = done;
      r.last_of_item = 1'b0;
      byte_res.push_back(r);
    endfunction

    // packet boundary: the row closes once its byte count is reached
    function void close_packet();
      out_item_t r;
      logic      row_done;
      row_done = (column >= row_width());
      if (row_done) begin
        column = '0;
        row    = row + 16'd1;
        if (row >= img_height) done = 1'b1;
      end
      if (byte_res.size() == 0) put(8'h00, 8'h00, 2'd0);
      if (row_done) begin
        r = byte_res[byte_res.size()-1];
        r.row_end    = 1'b1;
        r.image_done = done;
        byte_res[byte_res.size()-1] = r;
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t  r;
      logic [7:0] v;
      int         i;
      v = it.in_byte;
      byte_res.delete();
      if (it.frame_start) restart_frame();
      if (done) begin
        put(8'h00, 8'h00, 2'd0);
      end else if (!run_mode) begin
        put(v, 8'h00, 2'd1);
        column = column + 18'd1;
        close_packet();
      end else begin
        case (phase)
          PhRepeat: begin
            for (i = 0; i < repeat_len; i += 2) begin
              if (repeat_len - i >= 2) put(v, v, 2'd2);
              else put(v, 8'h00, 2'd1);
            end
            column = column + {10'd0, repeat_len};
            phase  = PhControl;
            close_packet();
          end
          PhLiteral: begin
            put(v, 8'h00, 2'd1);
            column       = column + 18'd1;
            literal_left = literal_left - 8'd1;
            if (literal_left == 8'd0) begin
              phase = PhControl;
              close_packet();
            end
          end
          default: begin
            if (v > LiteralMax) begin
              repeat_len = 8'(RunBase - {1'b0, v});
              phase      = PhRepeat;
            end else if (v == 8'd0) begin
              phase = PhControl;
              close_packet();
            end else begin
              literal_left = v;
              phase        = PhLiteral;
            end
          end
        endcase
      end
      if (byte_res.size() == 0) put(8'h00, 8'h00, 2'd0);
      r = byte_res[byte_res.size()-1];
      r.last_of_item = 1'b1;
      byte_res[byte_res.size()-1] = r;
      foreach (byte_res[k]) pending_q.push_back(byte_res[k]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: a=%h b=%h n=%0d row_end=%b done=%b last=%b",
                   got.out_byte_a, got.out_byte_b, got.byte_count, got.row_end,
                   got.image_done, got.last_of_item);
        return;
      end
      want = pending_q.pop_front();
      if (got.out_byte_a !== want.out_byte_a || got.out_byte_b !== want.out_byte_b ||
          got.byte_count !== want.byte_count || got.row_end !== want.row_end ||
          got.image_done !== want.image_done || got.last_of_item !== want.last_of_item) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  exp a=%h b=%h n=%0d row_end=%b done=%b last=%b",
                   want.out_byte_a, want.out_byte_b, want.byte_count, want.row_end,
                   want.image_done, want.last_of_item);
          $display("  got a=%h b=%h n=%0d row_end=%b done=%b last=%b",
                   got.out_byte_a, got.out_byte_b, got.byte_count, got.row_end,
                   got.image_done, got.last_of_item);
        end
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function logic image_finished();
      return done;
    endfunction

    function logic run_coded();
      return run_mode;
    endfunction
  endclass

endpackage

module bitmap_rle_row_decoder_tb;
  import brrd_pkg::*;
  import brrd_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  brrd_in_if  in_if ();
  brrd_out_if out_if ();
  brrd_cfg_if cfg_if ();

  rle_row_scoreboard sb;

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   sent_count = 0;
  logic hold_off = 1'b0;

  bitmap_rle_row_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // result side: check what was taken at this edge, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.payload);
    out_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] v, input logic fs);
    in_item_t it;
    int       gap;
    it.in_byte     = v;
    it.frame_start = fs;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(it);
    sent_count++;
  endtask

  task automatic send_literal(input int n, input logic fs);
    send_byte(8'(n), fs);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_run(input int n, input logic fs);
    send_byte(8'(RunBase - 9'(n)), fs);
    send_byte(8'($urandom), 1'b0);
  endtask

  task automatic configure(input logic [15:0] w, input logic [15:0] h,
                           input logic [4:0] d, input logic r);
    cfg_write_t wr [4];
    wr[0] = '{RegImageWidth, w};
    wr[1] = '{RegImageHeight, h};
    wr[2] = '{RegPixelDepth, {11'd0, d}};
    wr[3] = '{RegRunCoded, {15'd0, r}};
    foreach (wr[k]) begin
      cfg_if.valid   <= 1'b1;
      cfg_if.payload <= wr[k];
      do @(posedge clk_i); while (!cfg_if.ready);
      sb.write_reg(wr[k].reg_index, wr[k].reg_data);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // wait for every queued result, then let the pipeline go quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic stream_phase(input int budget);
    int   stop_at;
    int   pick;
    int   n;
    logic fs;
    stop_at = sent_count + budget;
    fs = 1'b1;
    while (sent_count < stop_at) begin
      if (sb.image_finished() && $urandom_range(3) == 0) fs = 1'b1;
      pick = $urandom_range(99);
      if (!sb.run_coded() || pick < 8) begin
        // raw data, or a stray byte that breaks the packet framing
        send_byte(8'($urandom), fs | ($urandom_range(31) == 0));
      end else if (pick < 50) begin
        pick = $urandom_range(99);
        if (pick < 80) n = $urandom_range(1, 6);
        else if (pick < 97) n = $urandom_range(1, 24);
        else n = LiteralMax;
        send_literal(n, fs);
      end else if (pick < 92) begin
        pick = $urandom_range(99);
        if (pick < 70) n = $urandom_range(2, 8);
        else if (pick < 95) n = $urandom_range(2, 128);
        else n = 128;
        send_run(n, fs);
      end else begin
        send_byte(8'h00, fs);
      end
      fs = 1'b0;
    end
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int         p;
    logic [4:0] d;
    sb = new();
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: raw, zero width and height, so one byte ends the image
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    settle();

    configure(16'd4, 16'd2, 5'd8, 1'b1);
    send_byte(8'h00, 1'b1);
    send_literal(3, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h33, 1'b0);
    settle();

    // zero row width: any packet, even an empty one, closes the row
    configure(16'd0, 16'd0, 5'd1, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h02, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    settle();

    for (p = 0; p < 12; p++) begin
      case (p)
        0: configure(16'd3, 16'd4, 5'd8, 1'b0);
        1: configure(16'd20, 16'd3, 5'd1, 1'b1);
        2: configure(16'd2, 16'd5, 5'd24, 1'b1);
        3: configure(16'd10, 16'hFFFF, 5'd4, 1'b1);
        4: configure(16'd0, 16'd0, 5'd23, 1'b1);
        5: configure(16'hFFFF, 16'hFFFF, 5'd24, 1'b1);
        6: configure(16'hFFFF, 16'd2, 5'd1, 1'b0);
        default: begin
          case ($urandom_range(4))
            0: d = 5'd1;
            1: d = 5'd4;
            2: d = 5'd8;
            3: d = 5'd24;
            default: d = 5'($urandom_range(1, 24));
          endcase
          configure(16'($urandom_range(40)), 16'($urandom_range(6)), d,
                    $urandom_range(3) != 0);
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 70; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 70; end
        default: begin send_idle_pct = 24; stall_pct <= 24; end
      endcase
      if (p == 3) begin
        // long output hold-off while input keeps coming, to back up the queue
        send_idle_pct = 0;
        fork
          begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off <= 1'b0;
          end
        join_none
      end
      stream_phase((p == 5 || p == 6) ? 25 : 40);
      settle();
    end

    repeat (24) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
